// ===== design/sri_pkg.sv =====
`timescale 1ns / 1ps
// shared types, widths and constants of the stepper ramp interval block
// no dependencies
package sri_pkg;

    localparam int ACCEL_FRAC_BITS = 16;
    localparam int ACCEL_W         = 32;
    localparam int INTERVAL_W      = 13;
    localparam int DELAY_W         = 16;
    localparam int SCALE_W         = 32;
    localparam int INDEX_W         = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int MUL_W           = 32;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int SQRT_BITS       = 13;
    localparam int SQRT_BIT_W      = 4;
    localparam int DIV_CNT_W       = 5;
    localparam int CAND_W          = 11;

    localparam logic [INTERVAL_W-1:0] RESTART_CAP_TO = 13'd5005;
    localparam logic [MUL_W-1:0]      RESTART_CAP_SQ = 32'd25100100;
    localparam logic [INTERVAL_W-1:0] RAMP_CAP_AT    = 13'd1010;
    localparam logic [INTERVAL_W-1:0] RAMP_CAP_TO    = 13'd1005;
    localparam logic [CAND_W-1:0]     MIN_CANDIDATE  = 11'd50;
    localparam logic [MUL_W-1:0]      CAND_BIG_AT    = 32'd1010;

    localparam logic signed [INDEX_W-1:0] RESTART_INDEX = 32'sd768;
    localparam logic signed [INDEX_W-1:0] INDEX_BIAS    = 32'sd64;
    localparam logic signed [INDEX_W:0]   INDEX_ONE     = 33'sd256;
    localparam logic signed [INDEX_W-1:0] INDEX_MAX     = 32'sh7fff_ffff;
    localparam logic signed [INDEX_W-1:0] INDEX_MIN     = 32'sh8000_0000;
    localparam logic signed [INDEX_W-1:0] INDEX_RESET   = 32'sd256;

    localparam logic signed [ACCEL_W-1:0] ACCEL_RESET =
        ACCEL_W'(longint'(1) << ACCEL_FRAC_BITS);

    localparam logic [SCALE_W-1:0] INIT_SCALE_RESET = 32'd1000000;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RESET  = 16'd10;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RESET  = 16'd5000;

    localparam logic [SQRT_BIT_W-1:0] SQRT_TOP_BIT = SQRT_BIT_W'(SQRT_BITS - 1);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST     = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_SCALE = 2'd0,
        CFG_MIN_DELAY  = 2'd1,
        CFG_MAX_DELAY  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_R_SQ,
        ST_R_CAPMUL,
        ST_R_CAPCMP,
        ST_R_TT,
        ST_R_TA,
        ST_R_TC,
        ST_CAND,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_APPLY,
        ST_FINISH
    } state_t;

    // clip a 33-bit signed value into the 32-bit index range
    function automatic logic signed [INDEX_W-1:0] sat_index(
        input logic signed [INDEX_W:0] v
    );
        logic signed [INDEX_W-1:0] r;
        if (v[INDEX_W] != v[INDEX_W-1])
            r = v[INDEX_W] ? INDEX_MIN : INDEX_MAX;
        else
            r = v[INDEX_W-1:0];
        return r;
    endfunction

    function automatic logic [INTERVAL_W-1:0] cap_ramp(
        input logic [INTERVAL_W-1:0] v
    );
        return (v > RAMP_CAP_AT) ? RAMP_CAP_TO : v;
    endfunction

endpackage

// ===== design/sri_if.sv =====
`timescale 1ns / 1ps
// channel interfaces of the stepper ramp interval block: step request,
// step result and register write; depends on sri_pkg
interface sri_req_if import sri_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ACCEL_W-1:0] accel;

    modport source (output valid, output accel, input ready);
    modport sink   (input valid, input accel, output ready);
endinterface

interface sri_res_if import sri_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] interval;
    logic [DELAY_W-1:0]    clamped_interval;
    logic                  direction;
    logic                  restarted;

    modport source (output valid, output interval, output clamped_interval,
                    output direction, output restarted, input ready);
    modport sink   (input valid, input interval, input clamped_interval,
                    input direction, input restarted, output ready);
endinterface

interface sri_cfg_if import sri_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/stepper_ramp_interval.sv =====
`timescale 1ns / 1ps
// stepper acceleration ramp: step interval sequencer with one shared multiplier
// and a restoring divider; depends on sri_pkg and sri_if

// Each step request word carries a signed Q16.16 acceleration (zero reuses the
// last one) and returns one result word with the raw interval, a copy clamped
// to min_delay/max_delay, the direction and a restart flag. Work is done by a
// small sequencer around one 32x32 multiplier and a one-bit-per-cycle restoring
// divider, one request at a time; step_req.ready is low while a request is in
// work. A restart runs a 13-bit square root search through the multiplier,
// each bit squaring a trial value and scaling it by the acceleration before
// the compare. A ramp step with changed acceleration adds a divider pass that
// rescales the index before the candidate interval pass. A finished word waits
// in the output register; the block takes the next request meanwhile. Register
// writes are taken in any cycle and are meant to happen only while the block
// is idle.
module stepper_ramp_interval import sri_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sri_req_if.sink    step_req,
    sri_res_if.source  step_res,
    sri_cfg_if.sink    cfg
);

    state_t state_reg, state_next;

    logic [SCALE_W-1:0] init_scale_reg;
    logic [DELAY_W-1:0] min_delay_reg;
    logic [DELAY_W-1:0] max_delay_reg;

    logic [INTERVAL_W-1:0]     cur_reg, cur_next;
    logic signed [INDEX_W-1:0] ri_reg, ri_next;
    logic signed [ACCEL_W-1:0] la_reg, la_next;
    logic                      dir_reg, dir_next;

    logic signed [ACCEL_W-1:0] a_reg, a_next;
    logic [MUL_W-1:0]          amag_reg, amag_next;
    logic                      restarted_reg, restarted_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [PROD_W-1:0]         s2_reg, s2_next;
    logic [SQRT_BITS-1:0]      q_reg, q_next;
    logic [SQRT_BIT_W-1:0]     bit_reg, bit_next;
    logic [MUL_W-1:0]          rem_reg, rem_next;
    logic [MUL_W-1:0]          dq_reg, dq_next;
    logic [MUL_W-1:0]          divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      neg_reg, neg_next;
    logic                      div_cand_reg, div_cand_next;
    logic [CAND_W-1:0]         cand_reg, cand_next;
    logic                      cand_big_reg, cand_big_next;

    logic                  out_valid_reg, out_valid_next;
    logic [INTERVAL_W-1:0] out_interval_reg, out_interval_next;
    logic [DELAY_W-1:0]    out_clamped_reg, out_clamped_next;
    logic                  out_dir_reg, out_dir_next;
    logic                  out_restarted_reg, out_restarted_next;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;

    logic                      req_take;
    logic                      res_take;
    logic                      out_free;
    logic                      restart_hit;
    logic                      accel_same;
    logic                      cand_in_range;
    logic [SQRT_BITS-1:0]      trial;
    logic [MUL_W:0]            rem_shift;
    logic                      rem_ge;
    logic                      div_ovf_hit;
    logic signed [INDEX_W:0]   diff_lo, diff_hi;
    logic [MUL_W-1:0]          mag_lo, mag_hi;
    logic [MUL_W-1:0]          ri_mag, la_mag;
    logic signed [ACCEL_W-1:0] a_eff;
    logic [DELAY_W-1:0]        cur_wide, clamp_lo;

    assign mul_p = mul_a * mul_b;

    assign req_take = step_req.valid && step_req.ready;
    assign res_take = step_res.valid && step_res.ready;
    assign out_free = !out_valid_reg || step_res.ready;

    assign restart_hit = (cur_reg == '0) ||
                         ((ri_reg > -RESTART_INDEX) && (ri_reg < RESTART_INDEX));
    assign accel_same  = (a_reg == la_reg);
    assign cand_in_range = (ri_reg >= INDEX_BIAS) || (ri_reg < -INDEX_BIAS);

    assign trial = q_reg | (SQRT_BITS'(1) << bit_reg);

    // restoring divider step: shift one dividend bit into the remainder
    assign rem_shift   = {rem_reg, dq_reg[MUL_W-1]};
    assign rem_ge      = rem_shift >= {1'b0, divisor_reg};
    assign div_ovf_hit = prod_reg[PROD_W-1:MUL_W] >= divisor_reg;

    assign diff_lo = $signed({ri_reg[INDEX_W-1], ri_reg}) - $signed({1'b0, INDEX_BIAS});
    assign diff_hi = $signed({ri_reg[INDEX_W-1], ri_reg}) + $signed({1'b0, INDEX_BIAS});
    assign mag_lo  = diff_lo[INDEX_W] ? MUL_W'(-diff_lo) : MUL_W'(diff_lo);
    assign mag_hi  = diff_hi[INDEX_W] ? MUL_W'(-diff_hi) : MUL_W'(diff_hi);
    assign ri_mag  = ri_reg[INDEX_W-1] ? MUL_W'(-ri_reg) : MUL_W'(ri_reg);
    assign la_mag  = la_reg[ACCEL_W-1] ? MUL_W'(-la_reg) : MUL_W'(la_reg);

    assign a_eff = (step_req.accel == '0) ? la_reg : step_req.accel;

    assign cur_wide = DELAY_W'(cur_reg);
    assign clamp_lo = (cur_wide < min_delay_reg) ? min_delay_reg : cur_wide;

    // handshake outputs
    assign step_req.ready = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;

    assign step_res.valid            = out_valid_reg;
    assign step_res.interval         = out_interval_reg;
    assign step_res.clamped_interval = out_clamped_reg;
    assign step_res.direction        = out_dir_reg;
    assign step_res.restarted        = out_restarted_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (restart_hit)
                    state_next = (amag_reg == '0) ? ST_FINISH : ST_R_SQ;
                else if (accel_same)
                    state_next = ST_CAND;
                else
                    state_next = ST_DIV_START;
            end
            ST_R_SQ:     state_next = ST_R_CAPMUL;
            ST_R_CAPMUL: state_next = ST_R_CAPCMP;
            ST_R_CAPCMP: state_next = (s2_reg > prod_reg) ? ST_FINISH : ST_R_TT;
            ST_R_TT:     state_next = ST_R_TA;
            ST_R_TA:     state_next = ST_R_TC;
            ST_R_TC:     state_next = (bit_reg == '0) ? ST_FINISH : ST_R_TT;
            ST_CAND:     state_next = cand_in_range ? ST_DIV_START : ST_APPLY;
            ST_DIV_START: state_next = div_ovf_hit ? ST_DIV_END : ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_DIV_END;
            end
            ST_DIV_END:  state_next = div_cand_reg ? ST_APPLY : ST_CAND;
            ST_APPLY:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        cur_next       = cur_reg;
        ri_next        = ri_reg;
        la_next        = la_reg;
        dir_next       = dir_reg;
        a_next         = a_reg;
        amag_next      = amag_reg;
        restarted_next = restarted_reg;
        prod_next      = prod_reg;
        s2_next        = s2_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        div_cand_next  = div_cand_reg;
        cand_next      = cand_reg;
        cand_big_next  = cand_big_reg;
        mul_a          = '0;
        mul_b          = '0;

        out_valid_next     = out_valid_reg && !res_take;
        out_interval_next  = out_interval_reg;
        out_clamped_next   = out_clamped_reg;
        out_dir_next       = out_dir_reg;
        out_restarted_next = out_restarted_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    a_next         = a_eff;
                    amag_next      = a_eff[ACCEL_W-1] ? MUL_W'(-a_eff) : MUL_W'(a_eff);
                    restarted_next = 1'b0;
                end
            end
            ST_START:
            begin
                if (restart_hit)
                begin
                    restarted_next = 1'b1;
                    dir_next       = !a_reg[ACCEL_W-1] && (a_reg != '0);
                    ri_next        = RESTART_INDEX;
                    if (amag_reg == '0)
                        cur_next = RESTART_CAP_TO;
                end
                else if (accel_same)
                begin
                    ri_next = sat_index($signed({ri_reg[INDEX_W-1], ri_reg}) + INDEX_ONE);
                end
                else
                begin
                    // rescale the index by last/new acceleration
                    mul_a         = ri_mag;
                    mul_b         = la_mag;
                    prod_next     = mul_p;
                    divisor_next  = amag_reg;
                    neg_next      = ri_reg[INDEX_W-1] ^ la_reg[ACCEL_W-1] ^ a_reg[ACCEL_W-1];
                    div_cand_next = 1'b0;
                end
            end
            ST_R_SQ:
            begin
                mul_a     = init_scale_reg;
                mul_b     = init_scale_reg;
                prod_next = mul_p;
            end
            ST_R_CAPMUL:
            begin
                s2_next   = prod_reg;
                mul_a     = RESTART_CAP_SQ;
                mul_b     = amag_reg;
                prod_next = mul_p;
            end
            ST_R_CAPCMP:
            begin
                if (s2_reg > prod_reg)
                    cur_next = RESTART_CAP_TO;
                q_next   = '0;
                bit_next = SQRT_TOP_BIT;
            end
            ST_R_TT:
            begin
                mul_a     = MUL_W'(trial);
                mul_b     = MUL_W'(trial);
                prod_next = mul_p;
            end
            ST_R_TA:
            begin
                mul_a     = MUL_W'(prod_reg[2*SQRT_BITS-1:0]);
                mul_b     = amag_reg;
                prod_next = mul_p;
            end
            ST_R_TC:
            begin
                if (prod_reg <= s2_reg)
                    q_next = trial;
                if (bit_reg == '0)
                    cur_next = (prod_reg <= s2_reg) ? trial : q_reg;
                else
                    bit_next = bit_reg - 1'b1;
            end
            ST_CAND:
            begin
                div_cand_next = 1'b1;
                if (cand_in_range)
                begin
                    // candidate = cur*(n-64)/(n+64), both taken as magnitudes
                    mul_a        = MUL_W'(cur_reg);
                    mul_b        = mag_lo;
                    prod_next    = mul_p;
                    divisor_next = mag_hi;
                end
                else
                begin
                    cand_next     = '0;
                    cand_big_next = 1'b0;
                end
            end
            ST_DIV_START:
            begin
                ovf_next = div_ovf_hit;
                rem_next = prod_reg[PROD_W-1:MUL_W];
                dq_next  = prod_reg[MUL_W-1:0];
                cnt_next = '0;
            end
            ST_DIV_RUN:
            begin
                rem_next = rem_ge ? MUL_W'(rem_shift - {1'b0, divisor_reg})
                                  : rem_shift[MUL_W-1:0];
                dq_next  = {dq_reg[MUL_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_DIV_END:
            begin
                if (div_cand_reg)
                begin
                    cand_big_next = ovf_reg || (dq_reg > CAND_BIG_AT);
                    cand_next     = dq_reg[CAND_W-1:0];
                end
                else if (neg_reg)
                begin
                    ri_next = (ovf_reg || (dq_reg > MUL_W'(INDEX_MIN))) ? INDEX_MIN
                                                                        : -$signed(dq_reg);
                end
                else
                begin
                    ri_next = (ovf_reg || dq_reg[MUL_W-1]) ? INDEX_MAX : $signed(dq_reg);
                end
            end
            ST_APPLY:
            begin
                if (cand_big_reg)
                    cur_next = RAMP_CAP_TO;
                else if (cand_reg > MIN_CANDIDATE)
                    cur_next = INTERVAL_W'(cand_reg);
                else
                begin
                    ri_next  = sat_index($signed({ri_reg[INDEX_W-1], ri_reg}) - INDEX_ONE);
                    cur_next = cap_ramp(cur_reg);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    la_next            = a_reg;
                    out_valid_next     = 1'b1;
                    out_interval_next  = cur_reg;
                    out_clamped_next   = (clamp_lo > max_delay_reg) ? max_delay_reg : clamp_lo;
                    out_dir_next       = dir_reg;
                    out_restarted_next = restarted_reg;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            init_scale_reg <= INIT_SCALE_RESET;
            min_delay_reg  <= MIN_DELAY_RESET;
            max_delay_reg  <= MAX_DELAY_RESET;
            cur_reg        <= '0;
            ri_reg         <= INDEX_RESET;
            la_reg         <= ACCEL_RESET;
            dir_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            ri_reg        <= ri_next;
            la_reg        <= la_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_INIT_SCALE: init_scale_reg <= cfg.data[SCALE_W-1:0];
                    CFG_MIN_DELAY:  min_delay_reg  <= cfg.data[DELAY_W-1:0];
                    CFG_MAX_DELAY:  max_delay_reg  <= cfg.data[DELAY_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg             <= a_next;
        amag_reg          <= amag_next;
        restarted_reg     <= restarted_next;
        prod_reg          <= prod_next;
        s2_reg            <= s2_next;
        q_reg             <= q_next;
        bit_reg           <= bit_next;
        rem_reg           <= rem_next;
        dq_reg            <= dq_next;
        divisor_reg       <= divisor_next;
        cnt_reg           <= cnt_next;
        ovf_reg           <= ovf_next;
        neg_reg           <= neg_next;
        div_cand_reg      <= div_cand_next;
        cand_reg          <= cand_next;
        cand_big_reg      <= cand_big_next;
        out_interval_reg  <= out_interval_next;
        out_clamped_reg   <= out_clamped_next;
        out_dir_reg       <= out_dir_next;
        out_restarted_reg <= out_restarted_next;
    end

endmodule
